>>> rtl/crde_pkg.sv
// Shared types and constants for the CAN record delta encoder.
package crde_pkg;

  localparam int TimeWidth  = 64;
  localparam int BusWidth   = 2;
  localparam int LenWidth   = 4;
  localparam int IdWidth    = 31;
  localparam int DataWidth  = 64;
  localparam int ByteWidth  = 8;
  localparam int GroupWidth = 7;

  localparam logic [LenWidth-1:0] MaxDataBytes = LenWidth'(8);

  localparam logic [1:0] SRC_VARINT = 2'd0;
  localparam logic [1:0] SRC_HEADER = 2'd1;
  localparam logic [1:0] SRC_IDENT  = 2'd2;
  localparam logic [1:0] SRC_DATA   = 2'd3;

  typedef logic [1:0] src_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic emit;
    src_t src;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic rest_zero;
    logic id_done;
    logic len_zero;
    logic data_last;
  } sts_t;

endpackage

>>> rtl/can_record_delta_encoder.sv
// Top level of the CAN record delta encoder: controller plus datapath.
//
//   channel | handshake             | word
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_ready   | timestamp_ms, bus_number, payload_length,
//           |                       | extended_id, frame_identifier, payload_bytes
//   out     | out_valid / out_ready | out_byte, last_byte
//
// A record is captured, then goes through the 64-bit clamp and subtract, then is
// emitted as 4 to 23 output bytes.
// The byte sequencer emits one byte per cycle into a single output register.
// Output stalls hold the sequencer; the next record is taken once the last byte
// is loaded, even while that byte still waits. Synchronous reset clears the
// state machine, output valid and the stored last timestamp.
module can_record_delta_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [crde_pkg::TimeWidth-1:0] timestamp_ms,
  input  logic [crde_pkg::BusWidth-1:0]  bus_number,
  input  logic [crde_pkg::LenWidth-1:0]  payload_length,
  input  logic                           extended_id,
  input  logic [crde_pkg::IdWidth-1:0]   frame_identifier,
  input  logic [crde_pkg::DataWidth-1:0] payload_bytes,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crde_pkg::ByteWidth-1:0] out_byte,
  output logic                           last_byte
);
  import crde_pkg::*;

  cmd_t cmd;
  sts_t sts;

  crde_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crde_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .timestamp_ms     (timestamp_ms),
    .bus_number       (bus_number),
    .payload_length   (payload_length),
    .extended_id      (extended_id),
    .frame_identifier (frame_identifier),
    .payload_bytes    (payload_bytes),
    .out_byte         (out_byte),
    .last_byte        (last_byte)
  );

endmodule

>>> rtl/crde_datapath.sv
// Datapath: record registers, delta compute, byte shifters and output word register.
module crde_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  crde_pkg::cmd_t                 cmd,
  output crde_pkg::sts_t                 sts,
  input  logic [crde_pkg::TimeWidth-1:0] timestamp_ms,
  input  logic [crde_pkg::BusWidth-1:0]  bus_number,
  input  logic [crde_pkg::LenWidth-1:0]  payload_length,
  input  logic                           extended_id,
  input  logic [crde_pkg::IdWidth-1:0]   frame_identifier,
  input  logic [crde_pkg::DataWidth-1:0] payload_bytes,
  output logic [crde_pkg::ByteWidth-1:0] out_byte,
  output logic                           last_byte
);
  import crde_pkg::*;

  logic [TimeWidth-1:0] previous_time;
  logic [TimeWidth-1:0] stamp;
  logic [TimeWidth-1:0] delta;
  logic [BusWidth-1:0]  bus;
  logic [LenWidth-1:0]  len;
  logic                 ext;
  logic [IdWidth-1:0]   ident;
  logic [DataWidth-1:0] data;
  logic [1:0]           id_count;
  logic [LenWidth-1:0]  data_count;

  logic [TimeWidth:0]   diff;
  logic [ByteWidth-1:0] byte_next;

  assign diff = {1'b0, stamp} - {1'b0, previous_time};

  always_comb begin
    unique case (cmd.src)
      SRC_VARINT: byte_next = {~sts.rest_zero, delta[GroupWidth-1:0]};
      SRC_HEADER: byte_next = {ext, 1'b0, bus, len};
      SRC_IDENT:  byte_next = ident[ByteWidth-1:0];
      SRC_DATA:   byte_next = data[ByteWidth-1:0];
      default:    byte_next = '0;
    endcase
  end

  assign sts.rest_zero = (delta[TimeWidth-1:GroupWidth] == '0);
  assign sts.id_done   = (id_count == 2'd3) || ((id_count == 2'd1) && !ext);
  assign sts.len_zero  = (len == '0);
  assign sts.data_last = (data_count == LenWidth'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time <= '0;
    end else if (cmd.calc && !diff[TimeWidth]) begin
      previous_time <= stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stamp      <= timestamp_ms;
      bus        <= bus_number;
      len        <= (payload_length > MaxDataBytes) ? MaxDataBytes : payload_length;
      data_count <= (payload_length > MaxDataBytes) ? MaxDataBytes : payload_length;
      ext        <= extended_id;
      ident      <= frame_identifier;
      data       <= payload_bytes;
      id_count   <= '0;
    end
    if (cmd.calc) begin
      delta <= diff[TimeWidth] ? '0 : diff[TimeWidth-1:0];
    end
    if (cmd.emit) begin
      out_byte  <= byte_next;
      last_byte <= cmd.last;
      unique case (cmd.src)
        SRC_VARINT: delta <= delta >> GroupWidth;
        SRC_HEADER: ;
        SRC_IDENT: begin
          ident    <= ident >> ByteWidth;
          id_count <= id_count + 2'd1;
        end
        SRC_DATA: begin
          data       <= data >> ByteWidth;
          data_count <= data_count - LenWidth'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/crde_controller.sv
// Controller: record sequencing state machine and output word valid.
module crde_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  crde_pkg::sts_t sts,
  output crde_pkg::cmd_t cmd
);
  import crde_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CALC   = 3'd1;
  localparam logic [2:0] ST_VARINT = 3'd2;
  localparam logic [2:0] ST_HEADER = 3'd3;
  localparam logic [2:0] ST_IDENT  = 3'd4;
  localparam logic [2:0] ST_DATA   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;
  logic       emitting;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign emitting  = slot_free && ((state == ST_VARINT) || (state == ST_HEADER) ||
                                   (state == ST_IDENT) || (state == ST_DATA));

  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.calc    = (state == ST_CALC);
    cmd.emit    = emitting;
    cmd.last    = 1'b0;
    cmd.src     = SRC_VARINT;
    state_next  = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CALC;
      end
      ST_CALC: state_next = ST_VARINT;
      ST_VARINT: begin
        cmd.src = SRC_VARINT;
        if (emitting && sts.rest_zero) state_next = ST_HEADER;
      end
      ST_HEADER: begin
        cmd.src = SRC_HEADER;
        if (emitting) state_next = ST_IDENT;
      end
      ST_IDENT: begin
        cmd.src  = SRC_IDENT;
        cmd.last = sts.id_done && sts.len_zero;
        if (emitting && sts.id_done) state_next = sts.len_zero ? ST_IDLE : ST_DATA;
      end
      ST_DATA: begin
        cmd.src  = SRC_DATA;
        cmd.last = sts.data_last;
        if (emitting && sts.data_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emitting) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the CAN record delta encoder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crde_pkg::*;

  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 30;
  localparam int PhaseItems  = 46;
  localparam int IdlePct[4]  = '{0, 51, 0, 21};
  localparam int StallPct[4] = '{0, 0, 51, 21};

  typedef struct packed {
    logic [TimeWidth-1:0] stamp;
    logic [BusWidth-1:0]  bus;
    logic [LenWidth-1:0]  length;
    logic                 ext;
    logic [IdWidth-1:0]   ident;
    logic [DataWidth-1:0] data;
  } record_t;

  typedef struct packed {
    logic [ByteWidth-1:0] value;
    logic                 is_last;
  } enc_byte_t;

  class byte_run_scoreboard;
    logic [TimeWidth-1:0] held_stamp;
    enc_byte_t            expected_bytes[$];
    int                   errors;

    function new();
      held_stamp = '0;
      errors = 0;
    endfunction

    function void note_record(record_t r);
      logic [TimeWidth-1:0] stamp;
      logic [TimeWidth-1:0] delta;
      logic [LenWidth-1:0]  len;
      logic [GroupWidth-1:0] group;
      enc_byte_t            tail;
      len = (r.length > MaxDataBytes) ? MaxDataBytes : r.length;
      stamp = (r.stamp < held_stamp) ? held_stamp : r.stamp;
      delta = stamp - held_stamp;
      held_stamp = stamp;
      do begin
        group = delta[GroupWidth-1:0];
        delta = delta >> GroupWidth;
        expected_bytes.push_back('{value: {delta != '0, group}, is_last: 1'b0});
      end while (delta != '0);
      expected_bytes.push_back('{value: {r.ext, 1'b0, r.bus, len}, is_last: 1'b0});
      expected_bytes.push_back('{value: r.ident[7:0], is_last: 1'b0});
      expected_bytes.push_back('{value: r.ident[15:8], is_last: 1'b0});
      if (r.ext) begin
        expected_bytes.push_back('{value: r.ident[23:16], is_last: 1'b0});
        expected_bytes.push_back('{value: {1'b0, r.ident[30:24]}, is_last: 1'b0});
      end
      for (int i = 0; i < int'(len); i++) begin
        expected_bytes.push_back('{value: r.data[8*i +: 8], is_last: 1'b0});
      end
      tail = expected_bytes.pop_back();
      tail.is_last = 1'b1;
      expected_bytes.push_back(tail);
    endfunction

    function void check_byte(logic [ByteWidth-1:0] value, logic is_last);
      enc_byte_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h last %b",
                 $time, value, is_last);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (value !== want.value) begin
          $display("%0t: out_byte mismatch, expected %h, actual %h",
                   $time, want.value, value);
          errors++;
        end
        if (is_last !== want.is_last) begin
          $display("%0t: last_byte mismatch, expected %b, actual %b",
                   $time, want.is_last, is_last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [TimeWidth-1:0] timestamp_ms;
  logic [BusWidth-1:0]  bus_number;
  logic [LenWidth-1:0]  payload_length;
  logic                 extended_id;
  logic [IdWidth-1:0]   frame_identifier;
  logic [DataWidth-1:0] payload_bytes;
  logic                 out_valid;
  logic                 out_ready;
  logic [ByteWidth-1:0] out_byte;
  logic                 last_byte;

  byte_run_scoreboard   sb;
  logic [TimeWidth-1:0] stim_prev;
  int                   idle_pct;
  int                   stall_pct;
  int                   hold_requests;

  can_record_delta_encoder i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .timestamp_ms     (timestamp_ms),
    .bus_number       (bus_number),
    .payload_length   (payload_length),
    .extended_id      (extended_id),
    .frame_identifier (frame_identifier),
    .payload_bytes    (payload_bytes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .last_byte        (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_byte(out_byte, last_byte);
      end
      if (in_valid && in_ready) begin
        sb.note_record('{stamp: timestamp_ms, bus: bus_number, length: payload_length,
                         ext: extended_id, ident: frame_identifier, data: payload_bytes});
      end
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is requested.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic record_t make_record(logic [TimeWidth-1:0] stamp,
                                          logic [BusWidth-1:0] bus,
                                          logic [LenWidth-1:0] length, logic ext,
                                          logic [IdWidth-1:0] ident,
                                          logic [DataWidth-1:0] data);
    record_t r;
    r.stamp  = stamp;
    r.bus    = bus;
    r.length = length;
    r.ext    = ext;
    r.ident  = ident;
    r.data   = data;
    return r;
  endfunction

  function automatic record_t random_record();
    record_t              r;
    logic [TimeWidth-1:0] wide;
    int                   k;
    int                   mode;
    wide = {$urandom, $urandom};
    k = $urandom_range(56, 0);
    mode = $urandom_range(99);
    if (mode < 70) begin
      r.stamp = stim_prev + ((k == 0) ? '0 : (wide >> (64 - k)));
    end else if (mode < 85) begin
      r.stamp = stim_prev;
    end else begin
      r.stamp = (stim_prev == '0) ? '0 : wide % stim_prev;
    end
    r.bus = BusWidth'($urandom);
    if ($urandom_range(99) < 80) begin
      r.length = LenWidth'($urandom_range(8, 0));
    end else begin
      r.length = LenWidth'($urandom_range(15, 9));
    end
    r.ext   = 1'($urandom);
    r.ident = IdWidth'($urandom);
    r.data  = {$urandom, $urandom};
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_record(input record_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    timestamp_ms     <= r.stamp;
    bus_number       <= r.bus;
    payload_length   <= r.length;
    extended_id      <= r.ext;
    frame_identifier <= r.ident;
    payload_bytes    <= r.data;
    if (r.stamp > stim_prev) begin
      stim_prev = r.stamp;
    end
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin : stimulus
    record_t r;
    sb = new();
    stim_prev = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    timestamp_ms = '0;
    bus_number = '0;
    payload_length = '0;
    extended_id = 1'b0;
    frame_identifier = '0;
    payload_bytes = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_record(make_record('0, 2'd0, 4'd0, 1'b0, '0, '0));
    send_record(make_record(stim_prev + 64'd127, 2'd1, 4'd1, 1'b1, '1, 64'hFF));
    send_record(make_record(stim_prev + 64'd128, 2'd2, 4'd8, 1'b0, '1, '1));
    send_record(make_record(stim_prev + 64'd16383, 2'd3, 4'd9, 1'b1, 31'h1234_5678,
                            64'h0123_4567_89AB_CDEF));
    send_record(make_record(stim_prev + 64'd16384, 2'd0, 4'd15, 1'b1, '0,
                            64'hA5A5_5A5A_F00F_0FF0));
    send_record(make_record(stim_prev - 64'd1000, 2'd1, 4'd3, 1'b0, 31'h0000_07FF,
                            64'h0000_0000_00C3_3C81));
    send_record(make_record(stim_prev, 2'd2, 4'd5, 1'b1, 31'h5555_5555,
                            64'h5555_5555_5555_5555));
    for (int k = 3; k <= 8; k++) begin
      r = random_record();
      r.stamp = stim_prev + ((64'd1 << (7 * k)) - 64'd1);
      send_record(r);
    end
    r = random_record();
    r.stamp = stim_prev + (64'd1 << 56);
    send_record(r);
    r = random_record();
    r.stamp = stim_prev + (64'd1 << 63);
    send_record(r);
    r = random_record();
    r.stamp = '0;
    send_record(r);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct = IdlePct[p];
      stall_pct = StallPct[p];
      repeat (PhaseItems) send_record(random_record());
      if (p == 1) begin
        idle_pct = 0;
        hold_requests++;
        repeat (12) send_record(random_record());
        wait_drained();
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    r = random_record();
    r.stamp = '1;
    send_record(r);
    r = random_record();
    r.stamp = 64'd5;
    send_record(r);
    wait_drained();

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
